// File: sv/assert_macros.svh
// Assertion macros shared by the rotated box bounds RTL.
// Needs clk and rst_n in the scope of each use; empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RBB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbb assertion failed");

// next-cycle implication
`define RBB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbb assertion failed");

`else

`define RBB_ASSERT_IMP(lbl, ante, cons)
`define RBB_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: sv/rbb_pkg.sv
// Shared types, register codes and fixed-point helpers for rotated_box_bounds.
// No dependencies.
package rbb_pkg;

  localparam int COORD_W = 32;
  localparam int COEF_W  = 18;
  localparam int WCOEF_W = COEF_W + 1;          // room for a negated coefficient
  localparam int PROD_W  = WCOEF_W + COORD_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int FRAC_W  = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [WCOEF_W-1:0] wcoef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // register index codes (byte address bits [3:2])
  localparam logic [1:0] REG_COS_A = 2'd0;
  localparam logic [1:0] REG_SIN_A = 2'd1;
  localparam logic [1:0] REG_COS_B = 2'd2;
  localparam logic [1:0] REG_SIN_B = 2'd3;

  localparam coef_t COS_RESET = 18'sd65536;
  localparam coef_t SIN_RESET = 18'sd0;

  localparam acc_t   RND_HALF  = acc_t'(1) <<< (FRAC_W - 1);
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // load enables of the two min/max tree levels
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } extent_ld_t;

  // round half up, drop 16 fraction bits, clamp to 32-bit signed
  function automatic coord_t rnd_sat(input acc_t s);
    acc_t r;
    logic signed [ACC_W-FRAC_W-1:0] q;
    r = s + RND_HALF;
    q = r[ACC_W-1:FRAC_W];
    if (q[ACC_W-FRAC_W-1:COORD_W-1] == {(ACC_W-FRAC_W-COORD_W+1){q[COORD_W-1]}}) begin
      return q[COORD_W-1:0];
    end else if (q[ACC_W-FRAC_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  function automatic coord_t cmin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: sv/rbb_if.sv
// Valid/ready channel interfaces: box request in, bounds result out.
// Depends on rbb_pkg.
interface rbb_box_if;
  logic               valid;
  logic               ready;
  logic               mode;
  rbb_pkg::coord_t    x_lower;
  rbb_pkg::coord_t    x_upper;
  rbb_pkg::coord_t    y_lower;
  rbb_pkg::coord_t    y_upper;
  rbb_pkg::coord_t    z_lower;
  rbb_pkg::coord_t    z_upper;

  modport source (output valid, mode, x_lower, x_upper, y_lower, y_upper, z_lower, z_upper,
                  input ready);
  modport sink (input valid, mode, x_lower, x_upper, y_lower, y_upper, z_lower, z_upper,
                output ready);
endinterface

interface rbb_ext_if;
  logic               valid;
  logic               ready;
  rbb_pkg::coord_t    x_min;
  rbb_pkg::coord_t    x_max;
  rbb_pkg::coord_t    y_min;
  rbb_pkg::coord_t    y_max;
  rbb_pkg::coord_t    z_min;
  rbb_pkg::coord_t    z_max;

  modport source (output valid, x_min, x_max, y_min, y_max, z_min, z_max, input ready);
  modport sink (input valid, x_min, x_max, y_min, y_max, z_min, z_max, output ready);
endinterface

// File: sv/rbb_extent.sv
// Two-level registered min/max tree over the eight rotated values of one axis.
// Depends on rbb_pkg.
module rbb_extent (
  input  logic                clk,
  input  rbb_pkg::extent_ld_t ld,
  input  rbb_pkg::coord_t     vals [8],
  output rbb_pkg::coord_t     min_v,
  output rbb_pkg::coord_t     max_v
);

  rbb_pkg::coord_t lo_nxt [2];
  rbb_pkg::coord_t hi_nxt [2];
  rbb_pkg::coord_t lo_r   [2];
  rbb_pkg::coord_t hi_r   [2];
  rbb_pkg::coord_t min_r;
  rbb_pkg::coord_t max_r;

  // level A: each half of four values down to one
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      lo_nxt[h] = rbb_pkg::cmin(rbb_pkg::cmin(vals[4*h], vals[4*h+1]),
                                rbb_pkg::cmin(vals[4*h+2], vals[4*h+3]));
      hi_nxt[h] = rbb_pkg::cmax(rbb_pkg::cmax(vals[4*h], vals[4*h+1]),
                                rbb_pkg::cmax(vals[4*h+2], vals[4*h+3]));
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (ld.ld_b) begin
      min_r <= rbb_pkg::cmin(lo_r[0], lo_r[1]);
      max_r <= rbb_pkg::cmax(hi_r[0], hi_r[1]);
    end
  end

  assign min_v = min_r;
  assign max_v = max_r;

endmodule

// File: sv/rotated_box_bounds.sv
// rotated_box_bounds: bounds of an axis-aligned box after a two-axis rotation.
// One request per cycle unless the full pipeline is stalled. Seven register stages with
// valid bits, the first loaded at the accept edge; a stalled result only blocks intake once
// every stage is full. Synchronous active-low reset clears valids and loads the identity
// rotation (cos 1.0, sin 0.0). Depends on rbb_pkg, rbb_if, rbb_extent.
`include "assert_macros.svh"

module rotated_box_bounds (
  input  logic                          clk,
  input  logic                          rst_n,
  rbb_box_if.sink                       in_box,
  rbb_ext_if.source                     out_ext,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbb_pkg::PADDR_W-1:0]   paddr,
  input  logic [rbb_pkg::PDATA_W-1:0]   pwdata,
  output logic [rbb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int NST = 7;

  // Both directions share one datapath of the form
  //   first pass:  a1 = c1*p0 - s1*p1,  a2 = s1*p0 + c1*p1,  t passes through
  //   second pass: e1 = c2*q  + s2*t,   e2 = c2*t  - s2*q
  // project:   p0/p1/t = x/y/z, (c1,s1)=(ca,sa), (c2,s2)=(cb,sb),  q=a2
  //            X=a1, Y=e1, Z=e2
  // deproject: p0/p1/t = y/z/x, (c1,s1)=(cb,sb), (c2,s2)=(ca,-sa), q=a1
  //            X=e2, Y=e1, Z=a2
  // Products are shared across corners: 8 multipliers in the first pass
  // (two values each of p0 and p1), 12 in the second (four q, two t).

  // ---------------- configuration registers ----------------
  rbb_pkg::coef_t cos_a_r, sin_a_r, cos_b_r, sin_b_r;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_a_r <= rbb_pkg::COS_RESET;
      sin_a_r <= rbb_pkg::SIN_RESET;
      cos_b_r <= rbb_pkg::COS_RESET;
      sin_b_r <= rbb_pkg::SIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rbb_pkg::REG_COS_A: cos_a_r <= pwdata[rbb_pkg::COEF_W-1:0];
        rbb_pkg::REG_SIN_A: sin_a_r <= pwdata[rbb_pkg::COEF_W-1:0];
        rbb_pkg::REG_COS_B: cos_b_r <= pwdata[rbb_pkg::COEF_W-1:0];
        rbb_pkg::REG_SIN_B: sin_b_r <= pwdata[rbb_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // reads return the sign-extended coefficient
  always_comb begin
    unique case (paddr[3:2])
      rbb_pkg::REG_COS_A: prdata = rbb_pkg::PDATA_W'(cos_a_r);
      rbb_pkg::REG_SIN_A: prdata = rbb_pkg::PDATA_W'(sin_a_r);
      rbb_pkg::REG_COS_B: prdata = rbb_pkg::PDATA_W'(cos_b_r);
      rbb_pkg::REG_SIN_B: prdata = rbb_pkg::PDATA_W'(sin_b_r);
      default:            prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // free[k]: stage k takes new contents this cycle (empty, or its contents move on).
  logic [NST-1:0] v_r;
  logic [NST-1:0] free;

  always_comb begin
    free[NST-1] = !v_r[NST-1] || out_ext.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      free[k] = !v_r[k] || free[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (free[0]) v_r[0] <= in_box.valid;
      for (int k = 1; k < NST; k++) begin
        if (free[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_box.ready  = free[0];
  assign out_ext.valid = v_r[NST-1];

  // ---------------- stage 0: operand and coefficient select ----------------
  rbb_pkg::coord_t p0_nxt [2], p1_nxt [2], t_nxt [2];
  rbb_pkg::wcoef_t c1_nxt, s1_nxt, c2_nxt, s2_nxt;

  always_comb begin
    if (in_box.mode) begin
      p0_nxt = '{in_box.y_lower, in_box.y_upper};
      p1_nxt = '{in_box.z_lower, in_box.z_upper};
      t_nxt  = '{in_box.x_lower, in_box.x_upper};
      c1_nxt = rbb_pkg::wcoef_t'(cos_b_r);
      s1_nxt = rbb_pkg::wcoef_t'(sin_b_r);
      c2_nxt = rbb_pkg::wcoef_t'(cos_a_r);
      s2_nxt = -rbb_pkg::wcoef_t'(sin_a_r);
    end else begin
      p0_nxt = '{in_box.x_lower, in_box.x_upper};
      p1_nxt = '{in_box.y_lower, in_box.y_upper};
      t_nxt  = '{in_box.z_lower, in_box.z_upper};
      c1_nxt = rbb_pkg::wcoef_t'(cos_a_r);
      s1_nxt = rbb_pkg::wcoef_t'(sin_a_r);
      c2_nxt = rbb_pkg::wcoef_t'(cos_b_r);
      s2_nxt = rbb_pkg::wcoef_t'(sin_b_r);
    end
  end

  logic            s0_mode_r;
  rbb_pkg::coord_t s0_p0_r [2], s0_p1_r [2], s0_t_r [2];
  rbb_pkg::wcoef_t s0_c1_r, s0_s1_r, s0_c2_r, s0_s2_r;

  always_ff @(posedge clk) begin
    if (free[0]) begin
      s0_mode_r <= in_box.mode;
      s0_p0_r   <= p0_nxt;
      s0_p1_r   <= p1_nxt;
      s0_t_r    <= t_nxt;
      s0_c1_r   <= c1_nxt;
      s0_s1_r   <= s1_nxt;
      s0_c2_r   <= c2_nxt;
      s0_s2_r   <= s2_nxt;
    end
  end

  // ---------------- stage 1: first-pass products ----------------
  rbb_pkg::prod_t cp0_nxt [2], sp0_nxt [2], cp1_nxt [2], sp1_nxt [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cp0_nxt[i] = rbb_pkg::prod_t'(s0_c1_r) * rbb_pkg::prod_t'(s0_p0_r[i]);
      sp0_nxt[i] = rbb_pkg::prod_t'(s0_s1_r) * rbb_pkg::prod_t'(s0_p0_r[i]);
      cp1_nxt[i] = rbb_pkg::prod_t'(s0_c1_r) * rbb_pkg::prod_t'(s0_p1_r[i]);
      sp1_nxt[i] = rbb_pkg::prod_t'(s0_s1_r) * rbb_pkg::prod_t'(s0_p1_r[i]);
    end
  end

  logic            s1_mode_r;
  rbb_pkg::coord_t s1_t_r [2];
  rbb_pkg::wcoef_t s1_c2_r, s1_s2_r;
  rbb_pkg::prod_t  s1_cp0_r [2], s1_sp0_r [2], s1_cp1_r [2], s1_sp1_r [2];

  always_ff @(posedge clk) begin
    if (free[1]) begin
      s1_mode_r <= s0_mode_r;
      s1_t_r    <= s0_t_r;
      s1_c2_r   <= s0_c2_r;
      s1_s2_r   <= s0_s2_r;
      s1_cp0_r  <= cp0_nxt;
      s1_sp0_r  <= sp0_nxt;
      s1_cp1_r  <= cp1_nxt;
      s1_sp1_r  <= sp1_nxt;
    end
  end

  // ---------------- stage 2: first-pass sums, round, saturate ----------------
  // index 2*i+j pairs p0 value i with p1 value j
  rbb_pkg::coord_t a1_c [4], a2_c [4];
  rbb_pkg::coord_t q_nxt [4], r_nxt [4];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        a1_c[2*i+j] = rbb_pkg::rnd_sat(rbb_pkg::acc_t'(s1_cp0_r[i])
                                       - rbb_pkg::acc_t'(s1_sp1_r[j]));
        a2_c[2*i+j] = rbb_pkg::rnd_sat(rbb_pkg::acc_t'(s1_sp0_r[i])
                                       + rbb_pkg::acc_t'(s1_cp1_r[j]));
      end
    end
    for (int k = 0; k < 4; k++) begin
      q_nxt[k] = s1_mode_r ? a1_c[k] : a2_c[k];   // feeds the second pass
      r_nxt[k] = s1_mode_r ? a2_c[k] : a1_c[k];   // already final
    end
  end

  logic            s2_mode_r;
  rbb_pkg::coord_t s2_t_r [2], s2_q_r [4], s2_r_r [4];
  rbb_pkg::wcoef_t s2_c2_r, s2_s2_r;

  always_ff @(posedge clk) begin
    if (free[2]) begin
      s2_mode_r <= s1_mode_r;
      s2_t_r    <= s1_t_r;
      s2_c2_r   <= s1_c2_r;
      s2_s2_r   <= s1_s2_r;
      s2_q_r    <= q_nxt;
      s2_r_r    <= r_nxt;
    end
  end

  // ---------------- stage 3: second-pass products ----------------
  rbb_pkg::prod_t cq_nxt [4], sq_nxt [4], ct_nxt [2], st_nxt [2];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cq_nxt[k] = rbb_pkg::prod_t'(s2_c2_r) * rbb_pkg::prod_t'(s2_q_r[k]);
      sq_nxt[k] = rbb_pkg::prod_t'(s2_s2_r) * rbb_pkg::prod_t'(s2_q_r[k]);
    end
    for (int m = 0; m < 2; m++) begin
      ct_nxt[m] = rbb_pkg::prod_t'(s2_c2_r) * rbb_pkg::prod_t'(s2_t_r[m]);
      st_nxt[m] = rbb_pkg::prod_t'(s2_s2_r) * rbb_pkg::prod_t'(s2_t_r[m]);
    end
  end

  logic            s3_mode_r;
  rbb_pkg::coord_t s3_r_r [4];
  rbb_pkg::prod_t  s3_cq_r [4], s3_sq_r [4], s3_ct_r [2], s3_st_r [2];

  always_ff @(posedge clk) begin
    if (free[3]) begin
      s3_mode_r <= s2_mode_r;
      s3_r_r    <= s2_r_r;
      s3_cq_r   <= cq_nxt;
      s3_sq_r   <= sq_nxt;
      s3_ct_r   <= ct_nxt;
      s3_st_r   <= st_nxt;
    end
  end

  // ---------------- stage 4: second-pass sums, axis steering ----------------
  // corner 2*k+m: q value k with t value m; each first-pass value shows up twice
  rbb_pkg::coord_t e1_c [8], e2_c [8];
  rbb_pkg::coord_t xs_nxt [8], ys_nxt [8], zs_nxt [8];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int m = 0; m < 2; m++) begin
        e1_c[2*k+m] = rbb_pkg::rnd_sat(rbb_pkg::acc_t'(s3_cq_r[k])
                                       + rbb_pkg::acc_t'(s3_st_r[m]));
        e2_c[2*k+m] = rbb_pkg::rnd_sat(rbb_pkg::acc_t'(s3_ct_r[m])
                                       - rbb_pkg::acc_t'(s3_sq_r[k]));
        xs_nxt[2*k+m] = s3_mode_r ? e2_c[2*k+m] : s3_r_r[k];
        ys_nxt[2*k+m] = e1_c[2*k+m];
        zs_nxt[2*k+m] = s3_mode_r ? s3_r_r[k] : e2_c[2*k+m];
      end
    end
  end

  rbb_pkg::coord_t s4_xs_r [8], s4_ys_r [8], s4_zs_r [8];

  always_ff @(posedge clk) begin
    if (free[4]) begin
      s4_xs_r <= xs_nxt;
      s4_ys_r <= ys_nxt;
      s4_zs_r <= zs_nxt;
    end
  end

  // ---------------- stages 5 and 6: min/max trees, result register ----------------
  rbb_pkg::extent_ld_t ext_ld;

  assign ext_ld.ld_a = free[NST-2];
  assign ext_ld.ld_b = free[NST-1];

  rbb_extent u_ext_x (
    .clk   (clk),
    .ld    (ext_ld),
    .vals  (s4_xs_r),
    .min_v (out_ext.x_min),
    .max_v (out_ext.x_max)
  );

  rbb_extent u_ext_y (
    .clk   (clk),
    .ld    (ext_ld),
    .vals  (s4_ys_r),
    .min_v (out_ext.y_min),
    .max_v (out_ext.y_max)
  );

  rbb_extent u_ext_z (
    .clk   (clk),
    .ld    (ext_ld),
    .vals  (s4_zs_r),
    .min_v (out_ext.z_min),
    .max_v (out_ext.z_max)
  );

  // ---------------- checks ----------------
  // an accepted request always lands in the first stage
  `RBB_ASSERT_NXT(a_req_enters, in_box.valid && in_box.ready, v_r[0])
  // a request leaving the first tree level always reaches the result register
  `RBB_ASSERT_NXT(a_req_reaches_out, v_r[NST-2] && free[NST-1], out_ext.valid)
  // a full pipe behind a stalled result takes no new request
  `RBB_ASSERT_IMP(a_full_blocks_in, (&v_r) && !out_ext.ready, !in_box.ready)

endmodule
